/* hdl/pee_pkg.sv */
// Shared types, codes and a helper function of the vibration motor duty engine.
`timescale 1ns / 1ps

package pee_pkg;

   // Default number of fraction bits of the internal duty value.
   localparam int unsigned DUTY_BITS_DEFAULT = 16;

   // Fixed widths of the word fields.
   localparam int unsigned DUTY_FIELD_BITS = 16;
   localparam int unsigned STEP_BITS       = 16;
   localparam int unsigned INTERVAL_BITS   = 10;
   localparam int unsigned CSR_INDEX_BITS  = 4;
   localparam int unsigned CSR_DATA_BITS   = 16;

   // Register reset values.
   localparam logic [15:0]              MIN_POWER_RESET     = 16'd9830;
   localparam logic [INTERVAL_BITS-1:0] FADE_INTERVAL_RESET = 10'd100;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] REG_MIN_POWER     = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FADE_INTERVAL = 4'd1;

   // Command codes.
   localparam logic [2:0] OP_INSTANT = 3'd0;
   localparam logic [2:0] OP_FADE    = 3'd1;
   localparam logic [2:0] OP_PULSE   = 3'd2;
   localparam logic [2:0] OP_FLASH   = 3'd3;
   localparam logic [2:0] OP_TICK    = 3'd4;

   // Effect modes.
   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_FADE  = 2'd1;
   localparam logic [1:0] MODE_PULSE = 2'd2;
   localparam logic [1:0] MODE_FLASH = 2'd3;

   typedef struct packed {
      logic [2:0]  op;
      logic [6:0]  level;
      logic [15:0] duration_ms;
      logic [15:0] flash_count;
   } req_word_type;

   typedef struct packed {
      logic [15:0] duty;
      logic        busy_res;
      logic [1:0]  mode;
   } rsp_word_type;

   // Percent to duty, rounded to nearest and saturated; used on constants only.
   function automatic logic [63:0] pct_to_duty(input int unsigned pct,
                                               input int unsigned db);
      logic [63:0] v;
      logic [63:0] top;
      v   = ((64'(pct) << db) + 64'd50) / 64'd100;
      top = (64'd1 << db) - 64'd1;
      if (v > top) begin
         v = top;
      end
      return v;
   endfunction

endpackage

/* hdl/pwm_effect_engine_top.sv */
// Top level of the vibration motor duty engine: command control, effect state and result word.
`timescale 1ns / 1ps

// The engine takes one word at a time on the request channel, either a command (instant, fade,
// pulse, flash) or a one millisecond tick, and answers every word with exactly one result word
// that carries the duty after it, a busy flag and the running effect mode. For instant, pulse,
// flash, tick and unused codes the word passes through the execute state and the output state,
// which registers the result once the result register is free; no new word is taken before
// then. A fade command runs a bit-serial divider twice, once for the number of steps and once
// for the step size, between those two states. A fade shorter than one interval needs only the
// first division. A result word waits in its own register while the next word is already being
// worked on, so a stalled result channel does not hold up the request side until a second
// result is ready. Configuration writes are always taken and should only be made while the
// engine is idle.

module pwm_effect_engine_top #(
   parameter int unsigned DUTY_BITS = pee_pkg::DUTY_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  pee_pkg::req_word_type                 req_word,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output pee_pkg::rsp_word_type                 rsp_word,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pee_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [pee_pkg::CSR_DATA_BITS-1:0]     csr_data
);

   localparam int unsigned SB       = pee_pkg::STEP_BITS;
   localparam int unsigned IB       = pee_pkg::INTERVAL_BITS;
   localparam int unsigned FB       = pee_pkg::DUTY_FIELD_BITS;
   // The divider must hold both the fade duration and the duty difference.
   localparam int unsigned DIV_BITS = (DUTY_BITS > SB) ? DUTY_BITS : SB;
   // Common width for rescaling between the 16 bit fields and the internal duty.
   localparam int unsigned WIDE     = (DUTY_BITS > FB) ? DUTY_BITS : FB;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_STEPS,
      S_INC,
      S_OUT
   } state_type;

   state_type                state_ff, state_in;
   pee_pkg::req_word_type    cmd_ff, cmd_in;
   logic [15:0]              min_power_ff, min_power_in;
   logic [IB-1:0]            interval_ff, interval_in;
   logic [DUTY_BITS-1:0]     duty_ff, duty_in;
   logic [1:0]               mode_ff, mode_in;
   logic [DUTY_BITS-1:0]     target_ff, target_in;
   logic [DUTY_BITS-1:0]     inc_mag_ff, inc_mag_in;
   logic                     inc_down_ff, inc_down_in;
   logic [SB-1:0]            tick_ff, tick_in;
   logic [SB-1:0]            period_ff, period_in;
   logic [SB-1:0]            flashes_done_ff, flashes_done_in;
   logic [SB-1:0]            flashes_limit_ff, flashes_limit_in;
   logic                     flash_on_ff, flash_on_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   pee_pkg::rsp_word_type    rsp_word_ff, rsp_word_in;

   // Percent to duty table, one entry for every 7 bit level.
   logic [DUTY_BITS-1:0]     pct_lut [128];
   logic [DUTY_BITS-1:0]     level_duty;

   logic [WIDE-1:0]          floor_wide;
   logic [DUTY_BITS-1:0]     floor_duty;
   logic [IB-1:0]            interval_nz;
   logic [SB-1:0]            period_nz;
   logic [SB-1:0]            tick_limit;
   logic [SB-1:0]            tick_next;
   logic [DUTY_BITS-1:0]     distance;
   logic [DUTY_BITS-1:0]     diff;
   logic                     goes_down;
   logic [SB-1:0]            flash_count_next;
   logic [WIDE-1:0]          duty_wide;

   logic                     div_start;
   logic [DIV_BITS-1:0]      div_dividend;
   logic [SB-1:0]            div_divisor;
   logic                     div_done;
   logic [DIV_BITS-1:0]      div_quotient;
   logic [SB-1:0]            steps;

   for (genvar g = 0; g < 128; g++) begin : g_pct
      assign pct_lut[g] = DUTY_BITS'(pee_pkg::pct_to_duty(g, DUTY_BITS));
   end

   assign level_duty = pct_lut[cmd_ff.level];

   // The floor register is Q0.16; line it up with the internal duty by its top bits.
   assign floor_wide = WIDE'(min_power_ff) << (WIDE - FB);
   assign floor_duty = floor_wide[WIDE-1 -: DUTY_BITS];

   // A zero interval or period behaves as one millisecond.
   assign interval_nz = (interval_ff == '0) ? IB'(1) : interval_ff;
   assign period_nz   = (period_ff == '0) ? SB'(1) : period_ff;
   assign tick_limit  = (mode_ff == pee_pkg::MODE_FADE) ? SB'(interval_nz) : period_nz;
   assign tick_next   = tick_ff + SB'(1);

   assign distance  = (target_ff >= duty_ff) ? target_ff - duty_ff : duty_ff - target_ff;
   assign goes_down = target_ff < duty_ff;
   assign diff      = distance;
   assign steps     = div_quotient[SB-1:0];

   assign flash_count_next = flashes_done_ff + SB'(1);

   pee_serial_div #(
      .DIVIDEND_BITS (DIV_BITS),
      .DIVISOR_BITS  (SB)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in         = state_ff;
      cmd_in           = cmd_ff;
      min_power_in     = min_power_ff;
      interval_in      = interval_ff;
      duty_in          = duty_ff;
      mode_in          = mode_ff;
      target_in        = target_ff;
      inc_mag_in       = inc_mag_ff;
      inc_down_in      = inc_down_ff;
      tick_in          = tick_ff;
      period_in        = period_ff;
      flashes_done_in  = flashes_done_ff;
      flashes_limit_in = flashes_limit_ff;
      flash_on_in      = flash_on_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_word_in      = rsp_word_ff;
      div_start        = 1'b0;
      div_dividend     = '0;
      div_divisor      = '0;

      // Register writes; anything beyond the two registers is ignored.
      if (csr_valid) begin
         if (csr_index == pee_pkg::REG_MIN_POWER) begin
            min_power_in = csr_data[15:0];
         end else if (csr_index == pee_pkg::REG_FADE_INTERVAL) begin
            interval_in = csr_data[IB-1:0];
         end
      end

      // The result register empties once its word is taken.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_word;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            state_in = S_OUT;
            // Every command (instant, fade, pulse, flash) cancels the running effect.
            if (cmd_ff.op inside {[pee_pkg::OP_INSTANT : pee_pkg::OP_FLASH]}) begin
               mode_in          = pee_pkg::MODE_IDLE;
               tick_in          = '0;
               flashes_done_in  = '0;
               flashes_limit_in = '0;
               flash_on_in      = 1'b0;
            end
            case (cmd_ff.op)
               pee_pkg::OP_INSTANT: begin
                  duty_in = level_duty;
               end
               pee_pkg::OP_FADE: begin
                  // The fade starts no lower than the floor.
                  target_in    = level_duty;
                  duty_in      = (duty_ff < floor_duty) ? floor_duty : duty_ff;
                  div_start    = 1'b1;
                  div_dividend = DIV_BITS'(cmd_ff.duration_ms);
                  div_divisor  = SB'(interval_nz);
                  state_in     = S_STEPS;
               end
               pee_pkg::OP_PULSE: begin
                  if (cmd_ff.duration_ms == '0) begin
                     duty_in = '0;
                  end else begin
                     duty_in   = level_duty;
                     period_in = cmd_ff.duration_ms;
                     mode_in   = pee_pkg::MODE_PULSE;
                  end
               end
               pee_pkg::OP_FLASH: begin
                  target_in        = level_duty;
                  period_in        = cmd_ff.duration_ms;
                  flashes_limit_in = cmd_ff.flash_count;
                  mode_in          = pee_pkg::MODE_FLASH;
               end
               pee_pkg::OP_TICK: begin
                  if (mode_ff != pee_pkg::MODE_IDLE) begin
                     if (tick_next < tick_limit) begin
                        tick_in = tick_next;
                     end else begin
                        tick_in = '0;
                        case (mode_ff)
                           pee_pkg::MODE_FADE: begin
                              if (distance <= inc_mag_ff) begin
                                 duty_in = target_ff;
                                 mode_in = pee_pkg::MODE_IDLE;
                              end else if (inc_down_ff) begin
                                 duty_in = duty_ff - inc_mag_ff;
                              end else begin
                                 duty_in = duty_ff + inc_mag_ff;
                              end
                           end
                           pee_pkg::MODE_PULSE: begin
                              duty_in = '0;
                              mode_in = pee_pkg::MODE_IDLE;
                           end
                           default: begin
                              // Flashing: toggle, and count each on phase.
                              if (flash_on_ff) begin
                                 duty_in     = '0;
                                 flash_on_in = 1'b0;
                                 if (flashes_done_ff >= flashes_limit_ff) begin
                                    flashes_done_in  = '0;
                                    flashes_limit_in = '0;
                                    mode_in          = pee_pkg::MODE_IDLE;
                                 end
                              end else begin
                                 duty_in         = target_ff;
                                 flash_on_in     = 1'b1;
                                 flashes_done_in = flash_count_next;
                                 if (flash_count_next >= flashes_limit_ff) begin
                                    flashes_done_in  = '0;
                                    flashes_limit_in = '0;
                                    mode_in          = pee_pkg::MODE_IDLE;
                                 end
                              end
                           end
                        endcase
                     end
                  end
               end
               default: begin
                  // Unused codes leave everything as it is.
               end
            endcase
         end

         S_STEPS: begin
            if (div_done) begin
               if (steps == '0) begin
                  // Too short for a single step: land on the target at once.
                  duty_in     = target_ff;
                  inc_mag_in  = '0;
                  inc_down_in = 1'b0;
                  state_in    = S_OUT;
               end else begin
                  inc_down_in  = goes_down;
                  div_start    = 1'b1;
                  div_dividend = DIV_BITS'(diff);
                  div_divisor  = steps;
                  state_in     = S_INC;
               end
            end
         end

         S_INC: begin
            if (div_done) begin
               // A step that truncates to nothing still moves by one unit.
               inc_mag_in = (div_quotient == '0) ? DUTY_BITS'(1)
                                                 : div_quotient[DUTY_BITS-1:0];
               mode_in    = pee_pkg::MODE_FADE;
               state_in   = S_OUT;
            end
         end

         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in         = 1'b1;
               rsp_word_in.duty     = duty_wide[FB-1:0];
               rsp_word_in.busy_res = (mode_ff != pee_pkg::MODE_IDLE);
               rsp_word_in.mode     = mode_ff;
               state_in             = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The duty field is the low 16 bits of the internal duty.
   assign duty_wide = WIDE'(duty_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         min_power_ff     <= pee_pkg::MIN_POWER_RESET;
         interval_ff      <= pee_pkg::FADE_INTERVAL_RESET;
         duty_ff          <= '0;
         mode_ff          <= pee_pkg::MODE_IDLE;
         target_ff        <= '0;
         inc_mag_ff       <= '0;
         inc_down_ff      <= 1'b0;
         tick_ff          <= '0;
         period_ff        <= '0;
         flashes_done_ff  <= '0;
         flashes_limit_ff <= '0;
         flash_on_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         min_power_ff     <= min_power_in;
         interval_ff      <= interval_in;
         duty_ff          <= duty_in;
         mode_ff          <= mode_in;
         target_ff        <= target_in;
         inc_mag_ff       <= inc_mag_in;
         inc_down_ff      <= inc_down_in;
         tick_ff          <= tick_in;
         period_ff        <= period_in;
         flashes_done_ff  <= flashes_done_in;
         flashes_limit_ff <= flashes_limit_in;
         flash_on_ff      <= flash_on_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign csr_ready = 1'b1;

endmodule

/* hdl/pee_serial_div.sv */
// Bit-serial restoring divider: one quotient bit per clock cycle.
`timescale 1ns / 1ps

module pee_serial_div #(
   parameter int unsigned DIVIDEND_BITS = 16,
   parameter int unsigned DIVISOR_BITS  = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIVIDEND_BITS-1:0] dividend,
   input  logic [DIVISOR_BITS-1:0]  divisor,
   output logic                     done,
   output logic [DIVIDEND_BITS-1:0] quotient
);

   localparam int unsigned COUNT_BITS = $clog2(DIVIDEND_BITS + 1);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [COUNT_BITS-1:0]    count_ff, count_in;
   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVISOR_BITS-1:0]  den_ff, den_in;
   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;

   logic [DIVISOR_BITS:0]    shifted;
   logic [DIVISOR_BITS:0]    trial;

   always_comb begin
      // Bring down the next dividend bit and try a subtraction.
      shifted  = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
      trial    = shifted - {1'b0, den_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quo_in   = quo_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = COUNT_BITS'(DIVIDEND_BITS);
         rem_in   = '0;
         den_in   = divisor;
         quo_in   = dividend;
      end else if (busy_ff) begin
         if (!trial[DIVISOR_BITS]) begin
            rem_in = trial[DIVISOR_BITS-1:0];
            quo_in = {quo_ff[DIVIDEND_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIVISOR_BITS-1:0];
            quo_in = {quo_ff[DIVIDEND_BITS-2:0], 1'b0};
         end
         count_in = count_ff - COUNT_BITS'(1);
         if (count_ff == COUNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
